// ===== rtl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types, constants and helper functions for the packed command list
// checker: opcode table, status and phase codes, saturating arithmetic.
// ----------------------------------------------------------------------------
package pcl_pkg;

    // Histogram size and counter width
    localparam int HIST_ENTRIES = 128;
    localparam int COUNT_BITS   = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Vertex opcode range
    localparam logic [7:0] VTX_FIRST = 8'h23;
    localparam logic [7:0] VTX_LAST  = 8'h28;

    // Every opcode with a defined parameter count; all others are unknown
    localparam int NUM_KNOWN = 38;
    localparam logic [7:0] KNOWN_OPS [NUM_KNOWN] = '{
        8'h00, 8'h11, 8'h15, 8'h41,
        8'h10, 8'h12, 8'h13, 8'h14, 8'h20, 8'h21, 8'h22, 8'h24,
        8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h30,
        8'h31, 8'h32, 8'h33, 8'h40, 8'h50, 8'h60, 8'h72,
        8'h23, 8'h71,
        8'h1B, 8'h1C, 8'h70,
        8'h1A,
        8'h17, 8'h19,
        8'h16, 8'h18,
        8'h34
    };

    typedef enum logic [1:0] {
        CMD_FEED  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ACCEPT  = 3'd0,
        ST_ENDED   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic {
        KIND_PACKET = 1'b0,
        KIND_PARAM  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_OPEN  = 2'd0,
        PHASE_ENDED = 2'd1,
        PHASE_ERROR = 2'd2
    } phase_t;

    typedef struct packed {
        logic       known;
        logic [5:0] words;
    } op_info_t;

    // Histogram update for one transfer
    typedef struct packed {
        logic            clear;
        logic [3:0]      inc;
        logic [3:0][7:0] op;
    } hist_ctl_t;

    // Parameter-word count of an opcode
    function automatic op_info_t op_info(input logic [7:0] op);
        op_info_t r;
        r.known = 1'b1;
        case (op) inside
            8'h00, 8'h11, 8'h15, 8'h41:
                r.words = 6'd0;
            8'h10, 8'h12, 8'h13, 8'h14, 8'h20, 8'h21, 8'h22, 8'h24,
            8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h30,
            8'h31, 8'h32, 8'h33, 8'h40, 8'h50, 8'h60, 8'h72:
                r.words = 6'd1;
            8'h23, 8'h71:
                r.words = 6'd2;
            8'h1B, 8'h1C, 8'h70:
                r.words = 6'd3;
            8'h1A:
                r.words = 6'd9;
            8'h17, 8'h19:
                r.words = 6'd12;
            8'h16, 8'h18:
                r.words = 6'd16;
            8'h34:
                r.words = 6'd32;
            default:
            begin
                r.known = 1'b0;
                r.words = 6'd0;
            end
        endcase
        return r;
    endfunction

    // Add up to seven to a counter, holding at the top value
    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                      input logic [2:0] n);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(n);
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    // Clip a counter to the 16-bit output range
    function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// ===== rtl/pcl_hist.sv =====
// ----------------------------------------------------------------------------
// pcl_hist
// Per-opcode histogram: one saturating counter cell for each known opcode,
// up to four increments per transfer, a synchronous clear and a query read.
// ----------------------------------------------------------------------------
module pcl_hist
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcl_pkg::hist_ctl_t                ctl,
    input  logic [6:0]                        query,
    output logic [pcl_pkg::COUNT_BITS-1:0]    count
);
    import pcl_pkg::*;

    logic [COUNT_BITS-1:0] cell_reg  [NUM_KNOWN];
    logic [COUNT_BITS-1:0] cell_next [NUM_KNOWN];
    logic [2:0]            hits      [NUM_KNOWN];

    // Count matching bytes per cell and work out the next count
    always_comb
    begin
        for (int i = 0; i < NUM_KNOWN; i++)
        begin
            hits[i] = 3'd0;
            for (int b = 0; b < 4; b++)
            begin
                if (ctl.inc[b] && (ctl.op[b] == KNOWN_OPS[i]) &&
                    (int'(KNOWN_OPS[i]) < HIST_ENTRIES))
                begin
                    hits[i] = hits[i] + 3'd1;
                end
            end
            cell_next[i] = ctl.clear ? '0 : sat_add(cell_reg[i], hits[i]);
        end
    end

    // Hold the counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KNOWN; i++)
            begin
                cell_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_KNOWN; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // Select the queried cell; unknown opcodes always read zero
    always_comb
    begin
        count = '0;
        for (int i = 0; i < NUM_KNOWN; i++)
        begin
            if ({1'b0, query} == KNOWN_OPS[i])
            begin
                count = cell_reg[i];
            end
        end
    end

endmodule

// ===== rtl/packed_gpu_command_list_checker.sv =====
// ----------------------------------------------------------------------------
// packed_gpu_command_list_checker
// Walks a packed display list one word per transfer, tracks owed parameter
// words, counts packets, commands and vertex commands, keeps a per-opcode
// histogram and flags unknown opcodes and lists that end too early.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                    Payload
//  -------  ---------------------------  ------------------------------------
//  item     item_valid / item_stall      command, word, last, query_opcode
//  result   result_valid / result_stall  status, word_kind, packets_seen,
//                                        commands_seen, vertex_commands_seen,
//                                        parameters_owed, queried_count
//
//  One item per cycle while the result side does not stall; once its item
//  transfers in, a result passes the input register, then the result register.
//  The four opcode-byte decodes and histogram increments are done in the
//  single logic stage between the two registers.
//  Reset clears all counters, the histogram cells and the list phase at once.
//  A stalled result holds the input register; item_stall rises only then.
// ----------------------------------------------------------------------------
module packed_gpu_command_list_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [31:0] word,
    input  logic        last,
    input  logic [6:0]  query_opcode,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic        word_kind,
    output logic [15:0] packets_seen,
    output logic [15:0] commands_seen,
    output logic [15:0] vertex_commands_seen,
    output logic [7:0]  parameters_owed,
    output logic [15:0] queried_count
);
    import pcl_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] word_reg;
    logic        last_reg;
    logic [6:0]  query_reg;

    // List state
    phase_t                phase_reg, phase_next;
    logic [7:0]            owed_reg, owed_next;
    logic [COUNT_BITS-1:0] pkt_reg, pkt_next;
    logic [COUNT_BITS-1:0] cmd_cnt_reg, cmd_cnt_next;
    logic [COUNT_BITS-1:0] vtx_reg, vtx_next;

    // Result register
    logic        res_valid_reg;
    status_t     status_reg, status_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] queried_reg, queried_next;

    logic                  accept;
    logic                  res_load;
    logic                  go;
    hist_ctl_t             hist_ctl;
    logic [COUNT_BITS-1:0] hist_count;

    // Packet walk results
    logic [3:0] counted;
    logic       stop_unknown;
    logic       stop_overrun;
    logic [7:0] words_sum;
    logic [2:0] cmd_add;
    logic [2:0] vtx_add;
    logic       feed_open;

    // Handshake: the result register frees up when empty or being taken
    assign res_load   = !res_valid_reg || !result_stall;
    assign go         = in_valid_reg && res_load;
    assign item_stall = in_valid_reg && !res_load;
    assign accept     = item_valid && !item_stall;
    assign feed_open  = (cmd_reg == CMD_FEED) && (phase_reg == PHASE_OPEN);

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            word_reg  <= word;
            last_reg  <= last;
            query_reg <= query_opcode;
        end
    end

    // Walk the four opcode bytes, stopping at the first one that fails
    always_comb
    begin
        op_info_t   info;
        logic [7:0] op;
        logic       alive;
        alive        = 1'b1;
        counted      = 4'd0;
        stop_unknown = 1'b0;
        stop_overrun = 1'b0;
        words_sum    = 8'd0;
        cmd_add      = 3'd0;
        vtx_add      = 3'd0;
        for (int b = 0; b < 4; b++)
        begin
            op   = word_reg[8*b +: 8];
            info = op_info(op);
            if (alive)
            begin
                if (!info.known)
                begin
                    stop_unknown = 1'b1;
                    alive        = 1'b0;
                end
                else if (last_reg && (info.words != 6'd0))
                begin
                    stop_overrun = 1'b1;
                    alive        = 1'b0;
                end
                else
                begin
                    counted[b] = 1'b1;
                    words_sum  = words_sum + 8'(info.words);
                    cmd_add    = cmd_add + 3'd1;
                    if ((op >= VTX_FIRST) && (op <= VTX_LAST))
                    begin
                        vtx_add = vtx_add + 3'd1;
                    end
                end
            end
        end
    end

    // Next list phase
    always_comb
    begin
        phase_next = phase_reg;
        case (cmd_reg)
            CMD_CLEAR:
            begin
                phase_next = PHASE_OPEN;
            end
            CMD_FEED:
            begin
                if (feed_open)
                begin
                    if (owed_reg != 8'd0)
                    begin
                        if (last_reg)
                        begin
                            phase_next = (owed_reg == 8'd1) ? PHASE_ENDED : PHASE_ERROR;
                        end
                    end
                    else if (stop_unknown || stop_overrun)
                    begin
                        phase_next = PHASE_ERROR;
                    end
                    else if (last_reg)
                    begin
                        phase_next = PHASE_ENDED;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Counters, histogram update and result fields
    always_comb
    begin
        owed_next      = owed_reg;
        pkt_next       = pkt_reg;
        cmd_cnt_next   = cmd_cnt_reg;
        vtx_next       = vtx_reg;
        status_next    = ST_ACCEPT;
        kind_next      = KIND_PACKET;
        queried_next   = 16'd0;
        hist_ctl.clear = 1'b0;
        hist_ctl.inc   = 4'd0;
        hist_ctl.op    = word_reg;
        case (cmd_reg)
            CMD_READ:
            begin
                queried_next = clip16(hist_count);
            end
            CMD_CLEAR:
            begin
                owed_next      = 8'd0;
                pkt_next       = '0;
                cmd_cnt_next   = '0;
                vtx_next       = '0;
                hist_ctl.clear = go;
            end
            CMD_FEED:
            begin
                if (!feed_open)
                begin
                    status_next = ST_IGNORED;
                end
                else if (owed_reg != 8'd0)
                begin
                    kind_next = KIND_PARAM;
                    owed_next = owed_reg - 8'd1;
                    if (last_reg)
                    begin
                        status_next = (owed_reg == 8'd1) ? ST_ENDED : ST_OVERRUN;
                    end
                end
                else
                begin
                    pkt_next     = sat_add(pkt_reg, 3'd1);
                    owed_next    = words_sum;
                    cmd_cnt_next = sat_add(cmd_cnt_reg, cmd_add);
                    vtx_next     = sat_add(vtx_reg, vtx_add);
                    hist_ctl.inc = go ? counted : 4'd0;
                    if (stop_unknown)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else if (stop_overrun)
                    begin
                        status_next = ST_OVERRUN;
                    end
                    else if (last_reg)
                    begin
                        status_next = ST_ENDED;
                    end
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    // Advance the list state when a transfer moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_OPEN;
            owed_reg    <= 8'd0;
            pkt_reg     <= '0;
            cmd_cnt_reg <= '0;
            vtx_reg     <= '0;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            owed_reg    <= owed_next;
            pkt_reg     <= pkt_next;
            cmd_cnt_reg <= cmd_cnt_next;
            vtx_reg     <= vtx_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg  <= status_next;
            kind_reg    <= kind_next;
            queried_reg <= queried_next;
        end
    end

    pcl_hist u_hist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (hist_ctl),
        .query (query_reg),
        .count (hist_count)
    );

    // Counters already hold the state after the item that sits in the result
    assign result_valid         = res_valid_reg;
    assign status               = status_reg;
    assign word_kind            = kind_reg;
    assign packets_seen         = clip16(pkt_reg);
    assign commands_seen        = clip16(cmd_cnt_reg);
    assign vertex_commands_seen = clip16(vtx_reg);
    assign parameters_owed      = owed_reg;
    assign queried_count        = queried_reg;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed command list checker. A short directed
// pass covers every command and each error path. Random lists follow,
// mostly well formed with random content and some deliberately broken. The
// sender works in bursts and the receiver stalls in runs, with one long
// hold-off. Every result is compared field by field against a predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import pcl_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         NO_OP       = -1;
    localparam int         HOLD_CYCLES = 200;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         SHOW_LIMIT  = 10;

    typedef struct {
        status_t     status;
        kind_t       kind;
        logic [15:0] packets;
        logic [15:0] commands;
        logic [15:0] vertices;
        logic [7:0]  owed;
        logic [15:0] queried;
    } list_result_t;

    // Predicts the checker's state and holds the results still to arrive
    class list_stats_board;
        phase_t                phase;
        logic [7:0]            owed;
        logic [COUNT_BITS-1:0] packets;
        logic [COUNT_BITS-1:0] commands;
        logic [COUNT_BITS-1:0] vertices;
        logic [COUNT_BITS-1:0] hist [HIST_ENTRIES];
        list_result_t          expected_q [$];
        int                    mismatches;

        function new();
            clear_counts();
            mismatches = 0;
        endfunction

        function void clear_counts();
            phase    = PHASE_OPEN;
            owed     = '0;
            packets  = '0;
            commands = '0;
            vertices = '0;
            foreach (hist[i])
                hist[i] = '0;
        endfunction

        function logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
            return (v == COUNT_MAX) ? v : v + 1'b1;
        endfunction

        // Parameter words that follow an opcode
        function int param_words(input logic [7:0] op);
            case (op)
                8'h00, 8'h11, 8'h15, 8'h41:
                    return 0;
                8'h10, 8'h12, 8'h13, 8'h14, 8'h20, 8'h21, 8'h22, 8'h24,
                8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h30,
                8'h31, 8'h32, 8'h33, 8'h40, 8'h50, 8'h60, 8'h72:
                    return 1;
                8'h23, 8'h71:
                    return 2;
                8'h1B, 8'h1C, 8'h70:
                    return 3;
                8'h1A:
                    return 9;
                8'h17, 8'h19:
                    return 12;
                8'h16, 8'h18:
                    return 16;
                8'h34:
                    return 32;
                default:
                    return NO_OP;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the state by one accepted transfer and queue its result
        function void note_item(input logic [1:0] cmd, input logic [31:0] w,
                                input logic lst, input logic [6:0] q);
            list_result_t r;
            logic [7:0]   op;
            int           n;
            int           b;
            logic         halt;
            r.status  = ST_ACCEPT;
            r.kind    = KIND_PACKET;
            r.queried = '0;
            case (cmd)
                CMD_READ:
                    r.queried = hist[q];
                CMD_CLEAR:
                    clear_counts();
                CMD_SPARE:
                    r.status = ST_IGNORED;
                default:
                begin
                    if (phase != PHASE_OPEN)
                        r.status = ST_IGNORED;
                    else if (owed != 0)
                    begin
                        r.kind = KIND_PARAM;
                        owed   = owed - 1'b1;
                        if (lst)
                        begin
                            if (owed == 0)
                            begin
                                r.status = ST_ENDED;
                                phase    = PHASE_ENDED;
                            end
                            else
                            begin
                                r.status = ST_OVERRUN;
                                phase    = PHASE_ERROR;
                            end
                        end
                    end
                    else
                    begin
                        packets = bump(packets);
                        halt    = 1'b0;
                        for (b = 0; b < 4; b++)
                        begin
                            op = w[8*b +: 8];
                            n  = param_words(op);
                            if (halt)
                                ;
                            else if (n == NO_OP)
                            begin
                                r.status = ST_UNKNOWN;
                                phase    = PHASE_ERROR;
                                halt     = 1'b1;
                            end
                            else if (lst && n > 0)
                            begin
                                r.status = ST_OVERRUN;
                                phase    = PHASE_ERROR;
                                halt     = 1'b1;
                            end
                            else
                            begin
                                owed     = owed + 8'(n);
                                commands = bump(commands);
                                if (op < HIST_ENTRIES)
                                    hist[op[6:0]] = bump(hist[op[6:0]]);
                                if (op >= VTX_FIRST && op <= VTX_LAST)
                                    vertices = bump(vertices);
                            end
                        end
                        if (r.status == ST_ACCEPT && lst)
                        begin
                            r.status = ST_ENDED;
                            phase    = PHASE_ENDED;
                        end
                    end
                end
            endcase
            r.packets  = packets;
            r.commands = commands;
            r.vertices = vertices;
            r.owed     = owed;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(input list_result_t got);
            list_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: status=%0d owed=%0d",
                             got.status, got.owed);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.kind !== want.kind ||
                got.packets !== want.packets || got.commands !== want.commands ||
                got.vertices !== want.vertices || got.owed !== want.owed ||
                got.queried !== want.queried)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                begin
                    $display("expected st=%0d kind=%0d pk=%0d cm=%0d vx=%0d ow=%0d q=%0d",
                             want.status, want.kind, want.packets, want.commands,
                             want.vertices, want.owed, want.queried);
                    $display("actual   st=%0d kind=%0d pk=%0d cm=%0d vx=%0d ow=%0d q=%0d",
                             got.status, got.kind, got.packets, got.commands,
                             got.vertices, got.owed, got.queried);
                end
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [1:0]  command      = '0;
    logic [31:0] word         = '0;
    logic        last         = 1'b0;
    logic [6:0]  query_opcode = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic        word_kind;
    logic [15:0] packets_seen;
    logic [15:0] commands_seen;
    logic [15:0] vertex_commands_seen;
    logic [7:0]  parameters_owed;
    logic [15:0] queried_count;

    list_stats_board board;
    list_result_t    seen;
    int              items_sent = 0;
    int              burst_left = 0;
    int              cycles     = 0;
    int              hold_left  = 0;
    int              run_left   = 0;
    bit              send_gaps  = 1'b0;
    bit              stall_on   = 1'b0;
    bit              hold_req   = 1'b0;
    bit              stalling   = 1'b0;

    packed_gpu_command_list_checker i_dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .command              (command),
        .word                 (word),
        .last                 (last),
        .query_opcode         (query_opcode),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .status               (status),
        .word_kind            (word_kind),
        .packets_seen         (packets_seen),
        .commands_seen        (commands_seen),
        .vertex_commands_seen (vertex_commands_seen),
        .parameters_owed      (parameters_owed),
        .queried_count        (queried_count)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: long hold-off on request, else runs of stall and flow
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else if (!stall_on)
            result_stall <= 1'b0;
        else
        begin
            if (run_left == 0)
            begin
                stalling = !stalling;
                run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            run_left--;
            result_stall <= stalling;
        end
    end

    // Note every input transfer and check every result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                seen.status   = status_t'(status);
                seen.kind     = kind_t'(word_kind);
                seen.packets  = packets_seen;
                seen.commands = commands_seen;
                seen.vertices = vertex_commands_seen;
                seen.owed     = parameters_owed;
                seen.queried  = queried_count;
                board.check_result(seen);
            end
            if (item_valid && !item_stall)
                board.note_item(command, word, last, query_opcode);
        end
    end

    // Offer one item and hold it until transferred; idle between bursts
    task automatic put_item(input logic [1:0] cmd, input logic [31:0] w,
                            input logic lst, input logic [6:0] q);
        int gap;
        item_valid   <= 1'b1;
        command      <= cmd;
        word         <= w;
        last         <= lst;
        query_opcode <= q;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (send_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 20);
                item_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly cheap opcodes, now and then one with a long parameter run
    function automatic logic [7:0] pick_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return KNOWN_OPS[$urandom_range(0, 28)];
        else if (r < 9)
            return KNOWN_OPS[$urandom_range(29, 32)];
        return KNOWN_OPS[$urandom_range(0, NUM_KNOWN - 1)];
    endfunction

    // One list: packets with their parameters, perhaps broken on purpose
    task automatic random_list();
        logic [32:0] words [$];
        int          pkt_at [$];
        logic [32:0] entry;
        logic [31:0] pkt;
        logic [7:0]  op;
        int          n_pk;
        int          p;
        int          b;
        int          k;
        int          owe;
        int          flaw;
        if ($urandom_range(0, 9) != 0)
            put_item(CMD_CLEAR, $urandom, 1'($urandom), 7'($urandom));
        flaw = $urandom_range(0, 9);
        n_pk = $urandom_range(1, 4);
        for (p = 0; p < n_pk; p++)
        begin
            owe = 0;
            for (b = 0; b < 4; b++)
            begin
                op             = pick_op();
                pkt[8*b +: 8]  = op;
                owe           += board.param_words(op);
            end
            pkt_at.insert(pkt_at.size(), words.size());
            words.insert(words.size(), {1'b0, pkt});
            repeat (owe)
                words.insert(words.size(), {1'b0, 32'($urandom)});
        end
        case (flaw)
            0:
            begin
                // plant an unknown opcode and cut the list after that packet
                k = pkt_at[$urandom_range(0, pkt_at.size() - 1)];
                do
                    op = 8'($urandom_range(0, 255));
                while (board.param_words(op) != NO_OP);
                entry = words[k];
                entry[8*$urandom_range(0, 3) +: 8] = op;
                entry[32] = 1'($urandom);
                words[k] = entry;
                while (words.size() > k + 1)
                    void'(words.pop_back());
            end
            1:
            begin
                // end the list at a random word
                k = $urandom_range(0, words.size() - 1);
                while (words.size() > k + 1)
                    void'(words.pop_back());
                entry     = words[k];
                entry[32] = 1'b1;
                words[k]  = entry;
            end
            2:
                ;
            default:
            begin
                entry     = words[words.size() - 1];
                entry[32] = 1'b1;
                words[words.size() - 1] = entry;
            end
        endcase
        foreach (words[i])
        begin
            k = $urandom_range(0, 39);
            if (k < 3)
            begin
                op = pick_op();
                put_item(CMD_READ, $urandom, 1'($urandom), op[6:0]);
            end
            else if (k == 3)
                put_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom),
                         7'($urandom));
            put_item(CMD_FEED, words[i][31:0], words[i][32], 7'($urandom));
        end
        // feed past the end now and then
        if ($urandom_range(0, 4) == 0)
            put_item(CMD_FEED, $urandom, 1'($urandom), 7'($urandom));
    endtask

    task automatic run_lists(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            random_list();
    endtask

    task automatic directed_items();
        put_item(CMD_READ,  32'hFFFF_FFFF, 1'b1, 7'h7F);   // empty histogram
        put_item(CMD_FEED,  32'h4115_1100, 1'b0, 7'h00);   // no parameters
        put_item(CMD_FEED,  32'h0071_0023, 1'b0, 7'h7F);   // four owed
        put_item(CMD_FEED,  32'hFFFF_FFFF, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'hA5A5_5A5A, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h1234_5678, 1'b1, 7'h00);   // clean end
        put_item(CMD_FEED,  32'h0000_0000, 1'b0, 7'h00);   // ignored after end
        put_item(CMD_READ,  32'h0000_0000, 1'b0, 7'h23);
        put_item(CMD_SPARE, 32'hFFFF_FFFF, 1'b1, 7'h7F);
        put_item(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 7'h7F);
        put_item(CMD_READ,  32'h0000_0000, 1'b0, 7'h23);   // cleared
        put_item(CMD_FEED,  32'hFF00_1000, 1'b0, 7'h00);   // unknown top byte
        put_item(CMD_FEED,  32'h0000_0000, 1'b0, 7'h00);   // ignored after error
        put_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h0000_0010, 1'b1, 7'h00);   // last packet owes words
        put_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h0000_0000, 1'b1, 7'h00);   // one-packet list
        put_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h10FE_0000, 1'b1, 7'h00);   // unknown before owing
        put_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'h0000_0016, 1'b0, 7'h00);   // sixteen owed
        put_item(CMD_FEED,  32'hFFFF_FFFF, 1'b1, 7'h00);   // list ends too early
        put_item(CMD_CLEAR, 32'h0000_0000, 1'b0, 7'h00);
        put_item(CMD_FEED,  32'hFFFF_FFFF, 1'b0, 7'h7F);   // unknown first byte
    endtask

    // Stimulus
    initial
    begin
        board = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_on = 1'b1;
        directed_items();
        drain();

        // random lists with bursts and stalls
        send_gaps = 1'b1;
        run_lists(190);

        // hold the receiver off while the sender keeps pushing
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        run_lists(90);
        drain();

        // flat out, then idling again
        stall_on = 1'b0;
        run_lists(130);
        stall_on  = 1'b1;
        send_gaps = 1'b1;
        run_lists(160);

        drain();
        repeat (8)
            @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
